// File: hdl/via_pkg.sv
// ---------------------------------------------------------------------------
// via_pkg: shared types and constants for the vector integer ALU
// Opcodes, lane count, divider depth and the payload carried beside it.
// ---------------------------------------------------------------------------
package via_pkg;

    localparam int LANES   = 4;
    localparam int DW      = 32;
    localparam int CNT_W   = 3;
    localparam int DIV_STG = 8;   // radix-16: four quotient bits per stage
    localparam int DIV_BPS = DW / DIV_STG;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,  OP_SUB = 4'd1,  OP_MUL = 4'd2,  OP_DIV = 4'd3,
        OP_MOD = 4'd4,  OP_GE  = 4'd5,  OP_GT  = 4'd6,  OP_LE  = 4'd7,
        OP_LT  = 4'd8,  OP_EQ  = 4'd9,  OP_NE  = 4'd10, OP_AND = 4'd11,
        OP_OR  = 4'd12, OP_NOT = 4'd13, OP_R14 = 4'd14, OP_R15 = 4'd15
    } op_t;

    // per-item control travelling beside the lanes
    typedef struct packed {
        op_t              op;
        logic [LANES-1:0] lane_en;
        logic             empty;
    } ctl_t;

endpackage

// File: hdl/via_lane.sv
// ---------------------------------------------------------------------------
// via_lane: one ALU lane
// Stage 0 registers operands; divider runs over DIV_STG stages, four bits a
// stage; simple ops and the multiply ride alongside; last stage selects.
// ---------------------------------------------------------------------------
module via_lane
(
    input  logic                         clk,
    input  logic                         en,
    input  via_pkg::op_t                 op,
    input  logic signed [via_pkg::DW-1:0] a,
    input  logic signed [via_pkg::DW-1:0] b,
    output logic signed [via_pkg::DW-1:0] result
);
    localparam int W = via_pkg::DW;
    localparam int S = via_pkg::DIV_STG;
    localparam int K = via_pkg::DIV_BPS;

    // stage 0: magnitudes and quick results
    logic [W-1:0] mag_a_reg, mag_b_reg, a_reg, b_reg;
    logic         neg_a_reg, neg_b_reg;
    logic [W-1:0] quick_reg;
    logic [W-1:0] quick_next;
    via_pkg::op_t op_reg;

    always_comb
    begin
        case (op)
            via_pkg::OP_ADD: quick_next = a + b;
            via_pkg::OP_SUB: quick_next = a - b;
            via_pkg::OP_GE:  quick_next = {{(W-1){1'b0}}, a >= b};
            via_pkg::OP_GT:  quick_next = {{(W-1){1'b0}}, a >  b};
            via_pkg::OP_LE:  quick_next = {{(W-1){1'b0}}, a <= b};
            via_pkg::OP_LT:  quick_next = {{(W-1){1'b0}}, a <  b};
            via_pkg::OP_EQ:  quick_next = {{(W-1){1'b0}}, a == b};
            via_pkg::OP_NE:  quick_next = {{(W-1){1'b0}}, a != b};
            via_pkg::OP_AND: quick_next = a & b;
            via_pkg::OP_OR:  quick_next = a | b;
            via_pkg::OP_NOT: quick_next = {{(W-1){1'b0}}, a == '0};
            default:         quick_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= a;
            b_reg     <= b;
            neg_a_reg <= a[W-1];
            neg_b_reg <= b[W-1];
            mag_a_reg <= a[W-1] ? (~a + 1'b1) : a;
            mag_b_reg <= b[W-1] ? (~b + 1'b1) : b;
            quick_reg <= quick_next;
            op_reg    <= op;
        end
    end

    // divider pipeline: restoring, K bits per stage, plus carried payload
    logic [W-1:0] rem_reg [S];
    logic [W-1:0] quo_reg [S];
    logic [W-1:0] dvs_reg [S];
    logic [W-1:0] car_reg [S];   // quick result, or product for multiply
    logic [W-1:0] sb_reg  [S];   // signed divisor kept for mod fix-up
    logic         na_reg  [S];
    logic         nb_reg  [S];
    via_pkg::op_t opp_reg [S];

    logic [W-1:0] prod_next;
    assign prod_next = a_reg * b_reg;

    for (genvar s = 0; s < S; s++)
    begin : g_div
        logic [W-1:0] r_in, q_in, d_in;
        logic [W-1:0] r_next, q_next;
        logic [W:0]   sh, t;

        assign r_in = (s == 0) ? '0 : rem_reg[(s == 0) ? 0 : s-1];
        assign q_in = (s == 0) ? mag_a_reg : quo_reg[(s == 0) ? 0 : s-1];
        assign d_in = (s == 0) ? mag_b_reg : dvs_reg[(s == 0) ? 0 : s-1];

        always_comb
        begin
            r_next = r_in;
            q_next = q_in;
            sh     = '0;
            t      = '0;
            for (int k = 0; k < K; k++)
            begin
                sh     = {r_next, q_next[W-1]};
                t      = sh - {1'b0, d_in};
                r_next = t[W] ? sh[W-1:0] : t[W-1:0];
                q_next = {q_next[W-2:0], ~t[W]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= r_next;
                quo_reg[s] <= q_next;
                dvs_reg[s] <= d_in;
                if (s == 0)
                begin
                    car_reg[s] <= (op_reg == via_pkg::OP_MUL) ? prod_next : quick_reg;
                    sb_reg[s]  <= b_reg;
                    na_reg[s]  <= neg_a_reg;
                    nb_reg[s]  <= neg_b_reg;
                    opp_reg[s] <= op_reg;
                end
                else
                begin
                    car_reg[s] <= car_reg[(s == 0) ? 0 : s-1];
                    sb_reg[s]  <= sb_reg[(s == 0) ? 0 : s-1];
                    na_reg[s]  <= na_reg[(s == 0) ? 0 : s-1];
                    nb_reg[s]  <= nb_reg[(s == 0) ? 0 : s-1];
                    opp_reg[s] <= opp_reg[(s == 0) ? 0 : s-1];
                end
            end
        end
    end

    // floored fix-up and final select
    logic [W-1:0] q_mag, r_mag, q_s, r_s, res_next, res_reg;
    logic         zero_b, rnz, diff;

    always_comb
    begin
        q_mag  = quo_reg[S-1];
        r_mag  = rem_reg[S-1];
        zero_b = (dvs_reg[S-1] == '0);
        rnz    = (r_mag != '0);
        diff   = na_reg[S-1] ^ nb_reg[S-1];
        q_s    = diff ? (~q_mag + 1'b1) : q_mag;
        r_s    = na_reg[S-1] ? (~r_mag + 1'b1) : r_mag;
        if (diff && rnz)
        begin
            q_s = q_s - 1'b1;
            r_s = r_s + sb_reg[S-1];
        end
        case (opp_reg[S-1])
            via_pkg::OP_DIV: res_next = zero_b ? '0 : q_s;
            via_pkg::OP_MOD: res_next = zero_b ? '0 : r_s;
            default:         res_next = car_reg[S-1];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign result = res_reg;

endmodule

// File: hdl/vector_integer_alu_top.sv
// ---------------------------------------------------------------------------
// vector_integer_alu_top: four-lane signed 32-bit vector ALU
// Element-wise add/sub/mul/div/mod, compares, and/or, not; pipelined.
// ---------------------------------------------------------------------------
// One transfer in and one transfer out per cycle while the output is not
// stalled. Items pass the operand register, the divider stages, which resolve
// four quotient bits a stage, and the result register; every other operation
// rides the same pipeline. The whole pipeline advances together; a stall
// on the output freezes it, and in_stall follows out_stall only while the
// pipeline holds a result that waits. Lanes at or above element_count give
// 0; a count of zero gives empty_error=1 and cost=0. Division by zero gives
// 0; the minimum over -1 gives the minimum for div and 0 for mod.
module vector_integer_alu_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [3:0]                    action,
    input  logic [via_pkg::CNT_W-1:0]     element_count,
    input  logic signed [via_pkg::DW-1:0] lane0_a,
    input  logic signed [via_pkg::DW-1:0] lane1_a,
    input  logic signed [via_pkg::DW-1:0] lane2_a,
    input  logic signed [via_pkg::DW-1:0] lane3_a,
    input  logic signed [via_pkg::DW-1:0] lane0_b,
    input  logic signed [via_pkg::DW-1:0] lane1_b,
    input  logic signed [via_pkg::DW-1:0] lane2_b,
    input  logic signed [via_pkg::DW-1:0] lane3_b,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [via_pkg::DW-1:0] lane0_result,
    output logic signed [via_pkg::DW-1:0] lane1_result,
    output logic signed [via_pkg::DW-1:0] lane2_result,
    output logic signed [via_pkg::DW-1:0] lane3_result,
    output logic                          empty_error,
    output logic                          cost
);
    localparam int DEPTH = via_pkg::DIV_STG + 2;

    // pipeline moves whenever the output is not blocked
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // valid bits and control shadow the lane pipeline
    logic [DEPTH-1:0] vld_reg;
    via_pkg::ctl_t    ctl_reg [DEPTH];
    via_pkg::ctl_t    ctl_next;

    always_comb
    begin
        ctl_next.op    = via_pkg::op_t'(action);
        ctl_next.empty = (element_count == '0);
        for (int i = 0; i < via_pkg::LANES; i++)
            ctl_next.lane_en[i] = (element_count > i[via_pkg::CNT_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0] <= ctl_next;
            for (int s = 1; s < DEPTH; s++)
                ctl_reg[s] <= ctl_reg[s-1];
        end
    end

    logic signed [via_pkg::DW-1:0] a_v [via_pkg::LANES];
    logic signed [via_pkg::DW-1:0] b_v [via_pkg::LANES];
    logic signed [via_pkg::DW-1:0] r_v [via_pkg::LANES];

    assign a_v[0] = lane0_a;  assign b_v[0] = lane0_b;
    assign a_v[1] = lane1_a;  assign b_v[1] = lane1_b;
    assign a_v[2] = lane2_a;  assign b_v[2] = lane2_b;
    assign a_v[3] = lane3_a;  assign b_v[3] = lane3_b;

    for (genvar l = 0; l < via_pkg::LANES; l++)
    begin : g_lane
        via_lane u_lane
        (
            .clk    (clk),
            .en     (adv),
            .op     (via_pkg::op_t'(action)),
            .a      (a_v[l]),
            .b      (b_v[l]),
            .result (r_v[l])
        );
    end

    via_pkg::ctl_t last;
    assign last = ctl_reg[DEPTH-1];

    assign out_valid    = vld_reg[DEPTH-1];
    assign lane0_result = last.lane_en[0] ? r_v[0] : '0;
    assign lane1_result = last.lane_en[1] ? r_v[1] : '0;
    assign lane2_result = last.lane_en[2] ? r_v[2] : '0;
    assign lane3_result = last.lane_en[3] ? r_v[3] : '0;
    assign empty_error  = last.empty;
    assign cost         = !last.empty;

`ifndef SYNTHESIS
    // output error and cost are always complementary
    a_cost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (empty_error != cost))
        else $error("cost/error mismatch");

    // a stalled result holds its valid bit through the pipeline
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result lost under stall");

    // input stall only when output is blocked
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("spurious input stall");
`endif

endmodule

// File: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the four-lane vector integer ALU
// Directed corners then randomised vectors through a queued driver with
// random gaps; a monitor under random stall checks each result lane by lane.
// ---------------------------------------------------------------------------
module tb_top;

    typedef logic signed [via_pkg::DW-1:0] word_t;

    typedef struct {
        via_pkg::op_t  op;
        logic [2:0]    cnt;
        word_t         a [via_pkg::LANES];
        word_t         b [via_pkg::LANES];
    } vec_item_t;

    typedef struct {
        word_t         res [via_pkg::LANES];
        logic          err;
        logic          cost;
    } vec_res_t;

    localparam int  RANDOM_ITEMS = 1250;
    localparam int  DRAIN_CYCLES = 40;       // pipeline depth plus margin
    localparam longint CYCLE_LIMIT = 200000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  action;
    logic [2:0]  element_count;
    word_t       lane0_a, lane1_a, lane2_a, lane3_a;
    word_t       lane0_b, lane1_b, lane2_b, lane3_b;
    logic        out_valid;
    logic        out_stall;
    word_t       lane0_result, lane1_result, lane2_result, lane3_result;
    logic        empty_error;
    logic        cost;

    vec_item_t   pending_q [$];
    vec_res_t    expected_q [$];
    int          mismatches = 0;
    int          sent_cnt = 0;
    int          checked_cnt = 0;
    int          err_cnt = 0;
    longint      cycle_cnt = 0;

    vector_integer_alu_top dut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .element_count(element_count),
        .lane0_a(lane0_a), .lane1_a(lane1_a), .lane2_a(lane2_a), .lane3_a(lane3_a),
        .lane0_b(lane0_b), .lane1_b(lane1_b), .lane2_b(lane2_b), .lane3_b(lane3_b),
        .out_valid(out_valid), .out_stall(out_stall),
        .lane0_result(lane0_result), .lane1_result(lane1_result),
        .lane2_result(lane2_result), .lane3_result(lane3_result),
        .empty_error(empty_error), .cost(cost)
    );

    always #5 clk = ~clk;

    // floored quotient; zero divisor gives 0, min / -1 wraps to min
    function automatic word_t floored_quot(word_t a, word_t b);
        longint q;
        longint r;
        if (b == 0)
            return '0;
        q = longint'(a) / longint'(b);
        r = longint'(a) % longint'(b);
        if (r != 0 && ((a < 0) != (b < 0)))
            q = q - 1;
        return word_t'(q[31:0]);
    endfunction

    // floored remainder, sign follows the divisor
    function automatic word_t floored_rem(word_t a, word_t b);
        longint r;
        if (b == 0)
            return '0;
        r = longint'(a) % longint'(b);
        if (r != 0 && ((r < 0) != (b < 0)))
            r = r + longint'(b);
        return word_t'(r[31:0]);
    endfunction

    function automatic word_t lane_calc(via_pkg::op_t op, word_t a, word_t b);
        case (op)
            via_pkg::OP_ADD: return a + b;
            via_pkg::OP_SUB: return a - b;
            via_pkg::OP_MUL: return a * b;
            via_pkg::OP_DIV: return floored_quot(a, b);
            via_pkg::OP_MOD: return floored_rem(a, b);
            via_pkg::OP_GE:  return word_t'(a >= b);
            via_pkg::OP_GT:  return word_t'(a > b);
            via_pkg::OP_LE:  return word_t'(a <= b);
            via_pkg::OP_LT:  return word_t'(a < b);
            via_pkg::OP_EQ:  return word_t'(a == b);
            via_pkg::OP_NE:  return word_t'(a != b);
            via_pkg::OP_AND: return a & b;
            via_pkg::OP_OR:  return a | b;
            via_pkg::OP_NOT: return word_t'(a == 0);
            default: return '0;
        endcase
    endfunction

    function automatic vec_res_t alu_predict(vec_item_t it);
        vec_res_t r;
        int       n;
        n = (it.cnt > via_pkg::LANES) ? via_pkg::LANES : it.cnt;
        for (int i = 0; i < via_pkg::LANES; i++)
            r.res[i] = (i < n) ? lane_calc(it.op, it.a[i], it.b[i]) : '0;
        r.err  = (n == 0);
        r.cost = (n != 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h (result %0d)",
                 what, got, want, checked_cnt);
        mismatches++;
    endtask

    // operand generator weighted towards corner values
    function automatic word_t pick_word();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -1;
            3: return 0;
            4: return word_t'($urandom_range(0, 7)) - 3;
            5: return word_t'($urandom_range(0, 511)) - 256;
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic queue_item(via_pkg::op_t op, int cnt, word_t a0, word_t b0);
        vec_item_t it;
        it.op  = op;
        it.cnt = cnt[2:0];
        for (int i = 0; i < via_pkg::LANES; i++)
        begin
            it.a[i] = (i == 0) ? a0 : pick_word();
            it.b[i] = (i == 0) ? b0 : pick_word();
        end
        pending_q.push_back(it);
    endtask

    // present the head of the pending queue
    task automatic drive_head();
        in_valid      <= 1'b1;
        action        <= pending_q[0].op;
        element_count <= pending_q[0].cnt;
        lane0_a <= pending_q[0].a[0]; lane0_b <= pending_q[0].b[0];
        lane1_a <= pending_q[0].a[1]; lane1_b <= pending_q[0].b[1];
        lane2_a <= pending_q[0].a[2]; lane2_b <= pending_q[0].b[2];
        lane3_a <= pending_q[0].a[3]; lane3_b <= pending_q[0].b[3];
    endtask

    // ---------------------------------------------------------------------
    // Driver: one transfer per accepted edge, random gap between items.
    // ---------------------------------------------------------------------
    int   gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        int wait_cycles;
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            gap_left      <= 0;
            action        <= '0;
            element_count <= '0;
            {lane0_a, lane1_a, lane2_a, lane3_a} <= '0;
            {lane0_b, lane1_b, lane2_b, lane3_b} <= '0;
        end
        else
        begin
            if (cycle_cnt > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_cnt);
                $display("tb_top: FAIL");
                $finish;
            end
            if (in_valid && !in_stall)
            begin
                expected_q.push_back(alu_predict(pending_q.pop_front()));
                sent_cnt++;
                wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                // a zero wait presents the next item on the very next cycle
                if (wait_cycles == 0 && pending_q.size() > 0)
                    drive_head();
                else
                begin
                    in_valid <= 1'b0;
                    gap_left <= (wait_cycles == 0) ? 0 : wait_cycles - 1;
                end
            end
            else if (!in_valid && pending_q.size() > 0)
            begin
                if (gap_left == 0)
                    drive_head();
                else
                    gap_left <= gap_left - 1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: random stall per result, checks oldest expectation.
    // ---------------------------------------------------------------------
    int   stall_left;

    always @(posedge clk or negedge rst_n)
    begin
        vec_res_t exp_r;
        int       stall_cycles;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            cycle_cnt++;
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("unexpected result transfer");
                    mismatches++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (lane0_result !== exp_r.res[0])
                        report_mismatch("lane0", lane0_result, exp_r.res[0]);
                    if (lane1_result !== exp_r.res[1])
                        report_mismatch("lane1", lane1_result, exp_r.res[1]);
                    if (lane2_result !== exp_r.res[2])
                        report_mismatch("lane2", lane2_result, exp_r.res[2]);
                    if (lane3_result !== exp_r.res[3])
                        report_mismatch("lane3", lane3_result, exp_r.res[3]);
                    if (empty_error !== exp_r.err)
                        report_mismatch("empty_error", empty_error, exp_r.err);
                    if (cost !== exp_r.cost)
                        report_mismatch("cost", cost, exp_r.cost);
                    if (exp_r.err)
                        err_cnt++;
                    checked_cnt++;
                end
                // draw the stall for the next result; at least a quarter run unstalled
                stall_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                if (stall_cycles == 0)
                    out_stall <= 1'b0;
                else
                begin
                    out_stall  <= 1'b1;
                    stall_left <= stall_cycles - 1;
                end
            end
            else if (stall_left > 0)
                stall_left <= stall_left - 1;
            else
                out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus and end of run.
    // ---------------------------------------------------------------------
    initial
    begin
        via_pkg::op_t  op;
        int            cnt;
        rst_n = 1'b0;

        // directed: every opcode at full width, then the corner cases
        for (int o = 0; o < 16; o++)
            queue_item(via_pkg::op_t'(o), 4, 32'sh7fff_ffff, 32'sh8000_0000);
        queue_item(via_pkg::OP_DIV, 4, 32'sh8000_0000, -1); // min over minus one
        queue_item(via_pkg::OP_MOD, 4, 32'sh8000_0000, -1);
        queue_item(via_pkg::OP_DIV, 1, 7, 0);               // divide by zero
        queue_item(via_pkg::OP_MOD, 2, -7, 0);
        queue_item(via_pkg::OP_DIV, 3, -7, 2);              // floored, rounds down
        queue_item(via_pkg::OP_MOD, 4, 7, -2);              // sign follows divisor
        queue_item(via_pkg::OP_ADD, 0, 1, 1);               // empty vector
        queue_item(via_pkg::OP_NOT, 7, 0, -1);              // count above lanes
        queue_item(via_pkg::OP_R15, 0, -1, -1);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            op  = via_pkg::op_t'($urandom_range(0, 9) == 0 ? $urandom_range(0, 15)
                                                           : $urandom_range(0, 13));
            cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
                                              : $urandom_range(1, 4);
            queue_item(op, cnt, pick_word(), pick_word());
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0 && expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transfers in, %0d results checked, %0d empty vectors",
                 sent_cnt, checked_cnt, err_cnt);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
